### src/tone_pattern_sequencer_assert.svh
// Assertion macros shared by the tone pattern sequencer RTL.
// No dependencies; included inside module bodies that use clk_i and rst_ni.
`ifndef TONE_PATTERN_SEQUENCER_ASSERT_SVH
`define TONE_PATTERN_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every clock edge, masked while reset is asserted.
`define TPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define TPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TPS_ASSERT(lbl, prop, msg)
`define TPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/tps_pkg.sv
// Package for the tone pattern sequencer: word types, command type, opcodes.
// No dependencies.
package tps_pkg;

  localparam int unsigned QueueDepthDef = 8;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } tps_op_e;

  // Input word
  typedef struct packed {
    logic        operation;
    logic [15:0] freq_hz;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] repeat_count;
  } tps_in_t;

  // Result word
  typedef struct packed {
    logic [15:0] drive_freq;
    logic        sounding;
    logic        busy_res;
    logic        push_dropped;
    logic [3:0]  queued;
  } tps_out_t;

  // One stored tone request
  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] reps;
  } tps_req_t;

  // Decoded command handed from front to back
  typedef struct packed {
    logic     is_push;
    tps_req_t req;
  } tps_cmd_t;

endpackage

### src/tps_front.sv
// Front end: accepts input words, decodes them into commands and buffers them
// in a two-entry queue toward the back end. Depends on tps_pkg.
module tps_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tps_pkg::tps_in_t   in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output tps_pkg::tps_cmd_t  cmd_o
);
  import tps_pkg::*;
  `include "tone_pattern_sequencer_assert.svh"

  tps_cmd_t   buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  tps_cmd_t   dec;

  always_comb begin
    dec.is_push      = (in_data_i.operation == OP_PUSH);
    dec.req.freq     = in_data_i.freq_hz;
    dec.req.on_ms    = in_data_i.on_ms;
    dec.req.off_ms   = in_data_i.off_ms;
    dec.req.reps     = in_data_i.repeat_count;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= dec;
    end
  end

  `TPS_ASSERT(a_fe_cnt_range, cnt_q != 2'd3, "command queue count out of range")
  `TPS_ASSERT(a_fe_empty_ptrs, (cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q), "empty queue skew")
  `TPS_ASSERT(a_fe_full_ptrs, (cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q), "full queue skew")

endmodule

### src/tps_back.sv
// Back end: request store, playback state and the result register.
// Reads the head request, then executes one command. Depends on tps_pkg.
module tps_back #(
  parameter int unsigned QUEUE_DEPTH = tps_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  tps_pkg::tps_cmd_t  cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tps_pkg::tps_out_t  out_data_o
);
  import tps_pkg::*;
  `include "tone_pattern_sequencer_assert.svh"

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e          state_q;
  tps_req_t        mem [QUEUE_DEPTH];
  tps_req_t        rd_q;
  tps_cmd_t        cmd_q;

  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            playing_q, playing_d;
  logic            tone_q, tone_d;
  logic [15:0]     elapsed_q, elapsed_d;
  logic [15:0]     phase_q, phase_d;
  logic [15:0]     cycles_q, cycles_d;
  logic            out_valid_q;
  tps_out_t        out_q, res_d;

  logic            commit;
  logic            wr_en;
  logic [15:0]     el_inc;
  logic [15:0]     reps_eff;
  logic [CntW+3:0] count_ext;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign commit      = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next playback state for the latched command, head entry in rd_q
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    playing_d = playing_q;
    tone_d    = tone_q;
    elapsed_d = elapsed_q;
    phase_d   = phase_q;
    cycles_d  = cycles_q;
    wr_en     = 1'b0;
    res_d.push_dropped = 1'b0;
    el_inc    = (elapsed_q < 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
    reps_eff  = (rd_q.reps == 16'd0) ? 16'd1 : rd_q.reps;

    if (cmd_q.is_push) begin
      if (count_q >= CntW'(QUEUE_DEPTH)) begin
        res_d.push_dropped = 1'b1;
      end else begin
        wr_en   = 1'b1;
        tail_d  = (tail_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + IdxW'(1);
        count_d = count_q + CntW'(1);
      end
    end else if (playing_q) begin
      elapsed_d = el_inc;
      if (el_inc >= phase_q) begin
        elapsed_d = 16'd0;
        if (tone_q) begin
          tone_d   = 1'b0;
          phase_d  = rd_q.off_ms;
          cycles_d = (cycles_q < 16'hFFFF) ? cycles_q + 16'd1 : cycles_q;
        end else if (cycles_q < reps_eff) begin
          tone_d  = 1'b1;
          phase_d = rd_q.on_ms;
        end else begin
          // retire the head entry and go quiet
          head_d    = (head_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IdxW'(1);
          count_d   = count_q - CntW'(1);
          playing_d = 1'b0;
          tone_d    = 1'b0;
        end
      end
    end else if (count_q != '0) begin
      playing_d = 1'b1;
      tone_d    = 1'b1;
      elapsed_d = 16'd0;
      phase_d   = rd_q.on_ms;
      cycles_d  = 16'd0;
    end

    count_ext        = {4'b0000, count_d};
    res_d.drive_freq = (playing_d && tone_d) ? rd_q.freq : 16'd0;
    res_d.sounding   = tone_d;
    res_d.busy_res   = playing_d;
    res_d.queued     = count_ext[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      playing_q   <= 1'b0;
      tone_q      <= 1'b0;
      elapsed_q   <= 16'd0;
      phase_q     <= 16'd0;
      cycles_q    <= 16'd0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // a new result replaces one taken at the same edge
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            head_q      <= head_d;
            tail_q      <= tail_d;
            count_q     <= count_d;
            playing_q   <= playing_d;
            tone_q      <= tone_d;
            elapsed_q   <= elapsed_d;
            phase_q     <= phase_d;
            cycles_q    <= cycles_d;
            out_q       <= res_d;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request store: one write port at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (commit && wr_en) begin
      mem[tail_q] <= cmd_q.req;
    end
    if (state_q == S_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
      rd_q  <= mem[head_q];
    end
  end

  `TPS_ASSERT(a_be_count_max, count_q <= CntW'(QUEUE_DEPTH), "entry count above depth")
  `TPS_ASSERT_ALWAYS(a_be_tone_needs_play, tone_q |-> playing_q, "tone on while idle")
  `TPS_ASSERT_ALWAYS(a_be_play_needs_entry, playing_q |-> (count_q != '0), "playing, no entry")
  `TPS_ASSERT_ALWAYS(a_be_empty_ptrs, (count_q == '0) |-> (head_q == tail_q), "empty store skew")
  `TPS_ASSERT(a_be_one_result, commit |=> out_valid_q, "committed word without a result")

endmodule

### src/tone_pattern_sequencer.sv
// Tone pattern sequencer: queued beep-pattern player, one result word per input word.
// A taken input word passes the front's queue (buf_q) and the back end's command
// latch (cmd_q, rd_q) before its result is registered in out_q. The back end takes
// no new command while it reads the head entry and executes; a stalled output holds it.
// Reset (rst_ni, async, active low) empties the queue and stops playback; the
// request store contents stay undefined until written.
module tone_pattern_sequencer #(
  parameter int unsigned QUEUE_DEPTH = tps_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tps_pkg::tps_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tps_pkg::tps_out_t out_data_o
);
  import tps_pkg::*;

  // Decoded commands between front and back; the front's two-entry queue
  // lets input words land while the back end waits on the output.
  logic     cmd_valid;
  logic     cmd_ready;
  tps_cmd_t cmd;

  // Front: takes words, decodes tick vs push, buffers them.
  tps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back: request store, phase timer and result register. A tick starts,
  // advances or retires the head request, and does nothing when the store is empty;
  // a push appends at the tail or is flagged as dropped when the store is full.
  tps_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
